@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication, disabled while the active-low reset is asserted.
`define XE_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Next-cycle implication.
`define XE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

@@ rtl/core/x86e_pkg.sv @@
// Package with payload types, form codes and byte constants of the encoder.
package x86e_pkg;

    typedef struct packed {
        logic [5:0]  opcode;
        logic [3:0]  cond;
        logic [3:0]  first_reg;
        logic [3:0]  second_reg;
        logic [63:0] value;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  code_byte;
        logic [15:0] byte_offset;
        logic        last_byte;
        logic        overflow_error;
    } t_out_word;

    // One encoded instruction, held in the queue between front and back.
    typedef struct packed {
        logic [9:0][7:0] bytes;
        logic [3:0]      len;
        logic            restart;
    } t_enc_word;

    localparam logic [5:0] OP_RESTART = 6'd44;
    localparam logic [7:0] B_MOV_ST = 8'h89;
    localparam logic [7:0] B_MOV_IMM = 8'hC7;
    localparam logic [7:0] B_MOV_WIDE = 8'hB8;
    localparam logic [7:0] B_ALU8 = 8'h83;
    localparam logic [7:0] B_ALU32 = 8'h81;
    localparam logic [7:0] B_ESC = 8'h0F;
    localparam logic [7:0] B_PFX_F2 = 8'hF2;
    localparam logic [7:0] B_JMP32 = 8'hE9;
    localparam logic [7:0] B_NOP = 8'h90;
    localparam logic [7:0] B_MOV_LD = 8'h8B;
    localparam logic [7:0] B_PFX_66 = 8'h66;
    localparam logic [7:0] B_POP = 8'h58;
    localparam logic [7:0] B_SIB_SP = 8'h24;

endpackage

@@ rtl/core/x86e_front.sv @@
// Front end: classifies a request and builds its byte string in one register stage.
module x86e_front import x86e_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_enc_word o_enc
);

    logic      r_valid;
    t_enc_word r_enc;
    t_enc_word n_enc;
    logic      n_keep;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_enc   = r_enc;

    // Encoding builder.
    always_comb begin
        logic [3:0] n;
        logic [3:0] f, s;
        logic [31:0] lo;
        logic sm8, fit32;
        logic [7:0] rx;
        logic [1:0] mdd;
        f  = i_word.first_reg;
        s  = i_word.second_reg;
        lo = i_word.value[31:0];
        sm8 = (lo[31:7] == 25'h0) || (lo[31:7] == 25'h1FFFFFF);
        fit32 = (i_word.value[63:31] == 33'h0) || (i_word.value[63:31] == 33'h1FFFFFFFF);
        n_enc = '0;
        n = '0;
        n_keep = 1'b1;
        rx = 8'h48 | {5'b0, f[3], 1'b0, s[3]};
        mdd = sm8 ? 2'd1 : 2'd2;
        n_enc.bytes = '0;
        unique case (i_word.opcode)
            6'd0: begin n_enc.bytes[0] = B_NOP; n = 4'd1; end
            6'd1: begin n_enc.bytes[0] = 8'hC3; n = 4'd1; end
            6'd2, 6'd3: begin
                if (f[3]) begin
                    n_enc.bytes[0] = 8'h41; n = 4'd1;
                end
                n_enc.bytes[n] = ((i_word.opcode == 6'd2) ? 8'h50 : B_POP) + {5'b0, f[2:0]};
                n = n + 4'd1;
            end
            6'd4, 6'd11, 6'd13, 6'd19, 6'd20, 6'd21, 6'd23, 6'd25: begin
                n_enc.bytes[0] = 8'h48 | {5'b0, s[3], 1'b0, f[3]};
                case (i_word.opcode)
                    6'd4:  n_enc.bytes[1] = B_MOV_ST;
                    6'd11: n_enc.bytes[1] = 8'h01;
                    6'd13: n_enc.bytes[1] = 8'h29;
                    6'd19: n_enc.bytes[1] = 8'h31;
                    6'd20: n_enc.bytes[1] = 8'h21;
                    6'd21: n_enc.bytes[1] = 8'h09;
                    6'd23: n_enc.bytes[1] = 8'h39;
                    default: n_enc.bytes[1] = 8'h85;
                endcase
                n_enc.bytes[2] = {2'b11, s[2:0], f[2:0]};
                n = 4'd3;
            end
            6'd5, 6'd6: begin
                n_enc.bytes[0] = 8'h48 | {7'b0, f[3]};
                if (i_word.opcode == 6'd6 || fit32) begin
                    n_enc.bytes[1] = B_MOV_IMM;
                    n_enc.bytes[2] = {5'b11000, f[2:0]};
                    {n_enc.bytes[6], n_enc.bytes[5], n_enc.bytes[4], n_enc.bytes[3]} = lo;
                    n = 4'd7;
                end else begin
                    n_enc.bytes[1] = B_MOV_WIDE + {5'b0, f[2:0]};
                    {n_enc.bytes[9], n_enc.bytes[8], n_enc.bytes[7], n_enc.bytes[6],
                     n_enc.bytes[5], n_enc.bytes[4], n_enc.bytes[3], n_enc.bytes[2]}
                        = i_word.value;
                    n = 4'd10;
                end
            end
            6'd7, 6'd9, 6'd8, 6'd10, 6'd33, 6'd35, 6'd36: begin
                if (i_word.opcode == 6'd35 || i_word.opcode == 6'd36) begin
                    n_enc.bytes[0] = B_PFX_F2; n = 4'd1;
                    if (f[3] || s[3]) begin
                        n_enc.bytes[1] = 8'h40 | {5'b0, f[3], 1'b0, s[3]}; n = 4'd2;
                    end
                    n_enc.bytes[n] = B_ESC;
                    n_enc.bytes[n + 4'd1] = (i_word.opcode == 6'd35) ? 8'h10 : 8'h11;
                    n = n + 4'd2;
                end else begin
                    n_enc.bytes[0] = rx;
                    case (i_word.opcode)
                        6'd7, 6'd8: n_enc.bytes[1] = B_MOV_LD;
                        6'd33:      n_enc.bytes[1] = 8'h8D;
                        default:    n_enc.bytes[1] = B_MOV_ST;
                    endcase
                    n = 4'd2;
                end
                if (i_word.opcode == 6'd7 || i_word.opcode == 6'd9) begin
                    if (s[2:0] == 3'd4) begin
                        n_enc.bytes[2] = {2'b00, f[2:0], 3'd4}; n_enc.bytes[3] = B_SIB_SP;
                        n = 4'd4;
                    end else if (s[2:0] == 3'd5) begin
                        n_enc.bytes[2] = {2'b01, f[2:0], 3'd5}; n_enc.bytes[3] = 8'h00;
                        n = 4'd4;
                    end else begin
                        n_enc.bytes[2] = {2'b00, f[2:0], s[2:0]}; n = 4'd3;
                    end
                end else begin
                    if (s[2:0] == 3'd4) begin
                        n_enc.bytes[n] = {mdd, f[2:0], 3'd4};
                        n_enc.bytes[n + 4'd1] = B_SIB_SP;
                        n = n + 4'd2;
                    end else begin
                        n_enc.bytes[n] = {mdd, f[2:0], s[2:0]};
                        n = n + 4'd1;
                    end
                    n_enc.bytes[n] = lo[7:0];
                    if (sm8) n = n + 4'd1;
                    else begin
                        n_enc.bytes[n + 4'd1] = lo[15:8];
                        n_enc.bytes[n + 4'd2] = lo[23:16];
                        n_enc.bytes[n + 4'd3] = lo[31:24];
                        n = n + 4'd4;
                    end
                end
            end
            6'd12, 6'd14, 6'd24: begin
                n_enc.bytes[0] = 8'h48 | {7'b0, f[3]};
                n_enc.bytes[1] = sm8 ? B_ALU8 : B_ALU32;
                case (i_word.opcode)
                    6'd12:   n_enc.bytes[2] = {5'b11000, f[2:0]};
                    6'd14:   n_enc.bytes[2] = {5'b11101, f[2:0]};
                    default: n_enc.bytes[2] = {5'b11111, f[2:0]};
                endcase
                {n_enc.bytes[6], n_enc.bytes[5], n_enc.bytes[4], n_enc.bytes[3]} = lo;
                n = sm8 ? 4'd4 : 4'd7;
            end
            6'd15, 6'd27: begin
                n_enc.bytes[0] = 8'h48 | {5'b0, f[3], 1'b0, s[3]};
                n_enc.bytes[1] = B_ESC;
                n_enc.bytes[2] = (i_word.opcode == 6'd15) ? 8'hAF : 8'hB6;
                n_enc.bytes[3] = {2'b11, f[2:0], s[2:0]};
                n = 4'd4;
            end
            6'd16, 6'd18, 6'd22: begin
                n_enc.bytes[0] = 8'h48 | {7'b0, f[3]};
                n_enc.bytes[1] = 8'hF7;
                case (i_word.opcode)
                    6'd16:   n_enc.bytes[2] = {5'b11111, f[2:0]};
                    6'd18:   n_enc.bytes[2] = {5'b11011, f[2:0]};
                    default: n_enc.bytes[2] = {5'b11010, f[2:0]};
                endcase
                n = 4'd3;
            end
            6'd17: begin n_enc.bytes[0] = 8'h48; n_enc.bytes[1] = 8'h99; n = 4'd2; end
            6'd26: begin
                if (f >= 4'd4) begin
                    n_enc.bytes[0] = 8'h40 | {7'b0, f[3]}; n = 4'd1;
                end
                n_enc.bytes[n] = B_ESC;
                n_enc.bytes[n + 4'd1] = 8'h90 + {4'b0, i_word.cond};
                n_enc.bytes[n + 4'd2] = {5'b11000, f[2:0]};
                n = n + 4'd3;
            end
            6'd28: begin n_enc.bytes[0] = B_JMP32; n = 4'd5; end
            6'd29: begin n_enc.bytes[0] = 8'hEB; n = 4'd2; end
            6'd30: begin
                n_enc.bytes[0] = B_ESC; n_enc.bytes[1] = 8'h80 + {4'b0, i_word.cond};
                n = 4'd6;
            end
            6'd31: begin
                n_enc.bytes[0] = 8'hE8;
                {n_enc.bytes[4], n_enc.bytes[3], n_enc.bytes[2], n_enc.bytes[1]} = lo;
                n = 4'd5;
            end
            6'd32: begin
                if (f[3]) begin
                    n_enc.bytes[0] = 8'h41; n = 4'd1;
                end
                n_enc.bytes[n] = 8'hFF;
                n_enc.bytes[n + 4'd1] = {5'b11010, f[2:0]};
                n = n + 4'd2;
            end
            6'd34, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41: begin
                n_enc.bytes[0] = (i_word.opcode == 6'd41) ? B_PFX_66 : B_PFX_F2;
                n = 4'd1;
                if (f[3] || s[3]) begin
                    n_enc.bytes[1] = 8'h40 | {5'b0, f[3], 1'b0, s[3]}; n = 4'd2;
                end
                n_enc.bytes[n] = B_ESC;
                case (i_word.opcode)
                    6'd34:   n_enc.bytes[n + 4'd1] = 8'h10;
                    6'd37:   n_enc.bytes[n + 4'd1] = 8'h58;
                    6'd38:   n_enc.bytes[n + 4'd1] = 8'h5C;
                    6'd39:   n_enc.bytes[n + 4'd1] = 8'h59;
                    6'd40:   n_enc.bytes[n + 4'd1] = 8'h5E;
                    default: n_enc.bytes[n + 4'd1] = 8'h2E;
                endcase
                n_enc.bytes[n + 4'd2] = {2'b11, f[2:0], s[2:0]};
                n = n + 4'd3;
            end
            6'd42, 6'd43: begin
                n_enc.bytes[0] = B_PFX_F2;
                n_enc.bytes[1] = 8'h48 | {5'b0, f[3], 1'b0, s[3]};
                n_enc.bytes[2] = B_ESC;
                n_enc.bytes[3] = (i_word.opcode == 6'd42) ? 8'h2A : 8'h2C;
                n_enc.bytes[4] = {2'b11, f[2:0], s[2:0]};
                n = 4'd5;
            end
            OP_RESTART: n_enc.restart = 1'b1;
            default: n_keep = 1'b0;
        endcase
        n_enc.len = n;
    end

    // Output stage of the front end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid && n_keep;
        end
        if (o_ready) begin
            r_enc <= n_enc;
        end
    end

endmodule

@@ rtl/core/x86e_queue.sv @@
// Two-entry queue of encoded instructions between front and back.
module x86e_queue import x86e_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_enc_word i_enc,
    output logic      o_valid,
    input  logic      i_ready,
    output t_enc_word o_enc
);

    t_enc_word  r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_enc   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wp] <= i_enc;
    end

endmodule

@@ rtl/core/x86e_back.sv @@
// Back end: sends the bytes one per cycle unless the output stalls, counts the offset and flags overflow.
module x86e_back import x86e_pkg::*; #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_enc_word   i_enc,
    input  logic [16:0] i_capacity,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_word   o_word
);

    localparam logic [16:0] OMASK = 17'((64'd1 << OFFSET_BITS) - 64'd1) & 17'hFFFF;

    logic [3:0]  r_idx;
    logic [16:0] r_off;
    logic        r_err;
    logic        r_valid;
    t_out_word   r_word;
    logic        w_load, w_full, w_last, w_take;
    logic [16:0] w_masked;

    assign o_valid  = r_valid;
    assign o_word   = r_word;
    assign w_load   = !r_valid || i_ready;
    assign w_last   = (r_idx + 4'd1 == i_enc.len);
    assign w_take   = i_valid && w_load;
    assign o_ready  = w_load && (i_enc.restart || w_last);
    assign w_full   = (r_off >= i_capacity);
    assign w_masked = r_off & OMASK;

    // Byte sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 4'd0; r_off <= 17'd0; r_err <= 1'b0; r_valid <= 1'b0;
        end else begin
            if (w_load) r_valid <= w_take && !i_enc.restart;
            if (w_take) begin
                if (i_enc.restart) begin
                    r_off <= 17'd0; r_err <= 1'b0;
                end else begin
                    r_idx <= w_last ? 4'd0 : r_idx + 4'd1;
                    if (w_full) r_err <= 1'b1;
                    else r_off <= r_off + 17'd1;
                end
            end
        end
        if (w_take) begin
            r_word.code_byte      <= i_enc.bytes[r_idx];
            r_word.byte_offset    <= w_masked[15:0];
            r_word.last_byte      <= w_last;
            r_word.overflow_error <= r_err || w_full;
        end
    end

endmodule

@@ rtl/core/x86_64_instruction_encoder.sv @@
// Top level of the x86-64 instruction encoder.
//   channel | direction | handshake           | payload
//   in      | in        | i_valid / o_ready   | i_in  (t_in_word)
//   out     | out       | o_valid / i_ready   | o_out (t_out_word)
//   cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (capacity)
// Each instruction yields as many output words as it has bytes, one to ten.
// A restart sends no bytes; unused forms are dropped in front.
// The back-end byte sequencer sets the rate; the front end encodes combinationally and registers the result.
// A two-entry queue lets the front end keep accepting while bytes drain.
// Synchronous reset clears offset, error flag and all valid state; capacity resets to 65536.
module x86_64_instruction_encoder import x86e_pkg::*; #(
    parameter int OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_word    i_in,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_word   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data
);

    logic [16:0] r_cap;
    logic        w_fv, w_fr, w_qv, w_qr;
    t_enc_word   w_fe, w_qe;

    assign o_cfg_ready = 1'b1;

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= 17'h10000;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    x86e_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_word(i_in),
        .o_valid(w_fv), .i_ready(w_fr), .o_enc(w_fe)
    );

    x86e_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_fr), .i_enc(w_fe),
        .o_valid(w_qv), .i_ready(w_qr), .o_enc(w_qe)
    );

    x86e_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_enc(w_qe),
        .i_capacity(r_cap), .o_valid, .i_ready, .o_word(o_out)
    );

endmodule

@@ rtl/core/x86e_checker.sv @@
// Port-level checker for the encoder, bound to the top level.
`include "assert_macros.svh"
module x86e_checker import x86e_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_word o_out
);

    logic [15:0] r_prev_off;
    logic        w_mid;
    logic        w_step_pre;
    logic        w_step_post;
    logic        w_err_pre;

    // Offset of the last word shown, for the step check.
    always_ff @(posedge i_clk) begin
        r_prev_off <= o_out.byte_offset;
    end

    // A word that is not the last of its instruction is followed by a new offset, an overflow flag or no valid word.
    assign w_mid       = o_valid && i_ready && !o_out.last_byte;
    assign w_step_pre  = w_mid && !o_out.overflow_error;
    assign w_step_post = !o_valid || o_out.overflow_error || (o_out.byte_offset != r_prev_off);
    assign w_err_pre   = w_mid && o_out.overflow_error;

    `XE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out))
    `XE_ASSERT_IMP(a_out_known, i_clk, i_rst_n, o_valid, !$isunknown(o_out))
    `XE_ASSERT_NEXT(a_off_step, i_clk, i_rst_n, w_step_pre, w_step_post)
    `XE_ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n, w_err_pre, o_valid && o_out.overflow_error)

endmodule

bind x86_64_instruction_encoder x86e_checker u_checker (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_out
);
